/* rtl/sba_pkg.sv */
// Shared types and constants for the segregated block allocator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sba_pkg;

  localparam int NUM_POOLS    = 16;
  localparam int MIN_POW      = 6;
  localparam int ADDR_BITS    = 24;
  localparam int INITIAL_END  = 64;
  localparam int HEADER_BYTES = 2;

  localparam int SLOT_BITS = ADDR_BITS - MIN_POW;
  localparam int POW_W     = $clog2(ADDR_BITS + 1);
  localparam int POOL_W    = 4;
  localparam int HDR_CLS_W = 6;
  localparam int END_W     = ADDR_BITS + 1;
  localparam int SUM_W     = ADDR_BITS + 2;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_RESERVED = 2'd1,
    ST_VALID    = 2'd2,
    ST_ACTIVE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RC_OK           = 3'd0,
    RC_TOO_LARGE    = 3'd1,
    RC_NO_SPACE     = 3'd2,
    RC_ALREADY_FREE = 3'd3,
    RC_BAD_HEADER   = 3'd4
  } rc_e;

  typedef struct packed {
    op_e         opcode;
    logic [23:0] request_size;
    logic [23:0] block_offset;
    logic [1:0]  new_status;
  } in_t;

  typedef struct packed {
    rc_e         result_code;
    logic [23:0] granted_offset;
    logic [3:0]  pool_index;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] link;
    logic [HDR_CLS_W-1:0] cls;
    status_e              status;
  } hdr_t;

  // decoded size class of a reserve request
  typedef struct packed {
    logic              too_large;
    logic [POOL_W-1:0] cls;
    logic [END_W-1:0]  bytes;
  } size_info_t;

endpackage

/* rtl/sba_size_class.sv */
// Size-class decoder: rounds a request up to a power of two of at least
// 2^MIN_POW bytes and gives the class, block bytes and oversize flag.
// Depends on sba_pkg.
`timescale 1ns / 1ps

module sba_size_class import sba_pkg::*; (
  input  logic [23:0] request_size,
  output size_info_t  info
);

  logic [23:0]      m;
  logic [POW_W-1:0] pow;
  logic [POW_W-1:0] pow_c;
  logic [POW_W-1:0] cls_full;

  always_comb begin
    m   = request_size - 24'd1;
    pow = '0;
    // bit length of size - 1 = ceil(log2(size))
    for (int i = 0; i < 24; i++) begin
      if (m[i]) pow = POW_W'(i + 1);
    end
    pow_c    = (pow < POW_W'(MIN_POW)) ? POW_W'(MIN_POW) : pow;
    cls_full = pow_c - POW_W'(MIN_POW);
    info.too_large = (request_size == 24'd0) || (cls_full >= POW_W'(NUM_POOLS));
    info.cls       = cls_full[POOL_W-1:0];
    info.bytes     = END_W'(1) << pow_c;
  end

endmodule

/* rtl/segregated_block_allocator.sv */
// Segregated power-of-two block allocator: header store memory, free-list
// heads, bump pointer and the read-modify-write sequencer.
// Depends on sba_pkg and sba_size_class.
//
// Usage:
//   in_valid/in_ready/in_data carry one request (reserve, release, mark or
//   no-op). out_valid/out_ready/out_data carry exactly one result per request.
//   The accept edge issues a read of the header store (one port, registered
//   read); the S_EXEC state then evaluates the entry, writes it back and
//   loads the result register. A new request is not accepted until the
//   previous one leaves S_EXEC, as the read-modify-write on the header store
//   allows only one request in flight.
//   The result register lets a new request be accepted while an earlier
//   result waits; if the receiver stalls with a result still pending, the
//   following request holds in its evaluate cycle until the register frees.
//   After rst_n a clearing pass zeroes all 2^18 = 262144 header store
//   entries, one entry per cycle, while in_ready stays low.
`timescale 1ns / 1ps

module segregated_block_allocator import sba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // header store
  hdr_t                 hdr_mem [2**SLOT_BITS];
  hdr_t                 rdata_r;
  logic                 mem_re;
  logic [SLOT_BITS-1:0] mem_raddr;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  hdr_t                 mem_wdata;

  logic [SLOT_BITS-1:0] clr_idx_r;

  logic [ADDR_BITS-1:0] class_heads_r [NUM_POOLS];
  logic [END_W-1:0]     end_r, end_nxt;

  // request captured at accept
  op_e                  op_r;
  logic                 too_large_r;
  logic [POOL_W-1:0]    cls_r;
  logic [END_W-1:0]     bytes_r;
  logic [ADDR_BITS-1:0] head_r;
  logic [23:0]          offset_r;
  logic [1:0]           status_r;

  logic out_valid_r;
  out_t out_data_r;

  size_info_t        si;
  logic              accept;
  logic              can_load;
  logic              exec_go;
  logic [POOL_W-1:0] head_idx;
  logic [ADDR_BITS-1:0] head_val;

  // evaluate-cycle results
  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  hdr_t                 wr_data;
  logic                 heads_we;
  logic [POOL_W-1:0]    heads_widx;
  logic [ADDR_BITS-1:0] heads_wdata;
  out_t                 res;
  logic [SUM_W-1:0]     bump_sum;
  logic [POOL_W-1:0]    hdr_pool;

  sba_size_class u_size (
    .request_size (in_data.request_size),
    .info         (si)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign exec_go   = (state_r == S_EXEC) && can_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hdr_pool  = rdata_r.cls[POOL_W-1:0];

  // one read of the head array per cycle: request class at accept,
  // stored class while evaluating a release
  assign head_idx = (state_r == S_IDLE) ? si.cls : hdr_pool;
  assign head_val = class_heads_r[head_idx];

  assign mem_re    = accept;
  assign mem_raddr = (in_data.opcode == OP_RESERVE) ? head_val[ADDR_BITS-1:MIN_POW]
                                                    : in_data.block_offset[ADDR_BITS-1:MIN_POW];
  assign mem_we    = (state_r == S_CLEAR) || (exec_go && wr_en);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_idx_r : wr_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? hdr_t'('0) : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) hdr_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= hdr_mem[mem_raddr];
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    heads_we    = 1'b0;
    heads_widx  = cls_r;
    heads_wdata = '0;
    end_nxt     = end_r;
    bump_sum    = SUM_W'(end_r) + SUM_W'(HEADER_BYTES) + SUM_W'(bytes_r);
    res.result_code    = RC_OK;
    res.granted_offset = '0;
    res.pool_index     = '0;
    unique case (op_r)
      OP_RESERVE: begin
        if (too_large_r) begin
          res.result_code = RC_TOO_LARGE;
        end else if (head_r != '0) begin
          // pop the free list
          heads_we           = 1'b1;
          heads_wdata        = rdata_r.link;
          wr_en              = 1'b1;
          wr_addr            = head_r[ADDR_BITS-1:MIN_POW];
          wr_data.status     = ST_RESERVED;
          wr_data.cls        = HDR_CLS_W'(cls_r);
          res.granted_offset = head_r;
          res.pool_index     = cls_r;
        end else if (bump_sum > (SUM_W'(1) << ADDR_BITS)) begin
          res.result_code = RC_NO_SPACE;
          res.pool_index  = cls_r;
        end else begin
          end_nxt            = bump_sum[END_W-1:0];
          wr_en              = 1'b1;
          wr_addr            = end_r[ADDR_BITS-1:MIN_POW];
          wr_data.status     = ST_RESERVED;
          wr_data.cls        = HDR_CLS_W'(cls_r);
          res.granted_offset = end_r[ADDR_BITS-1:0];
          res.pool_index     = cls_r;
        end
      end
      OP_RELEASE, OP_MARK: begin
        res.pool_index = hdr_pool;
        if (rdata_r.cls >= HDR_CLS_W'(NUM_POOLS)) begin
          res.result_code = RC_BAD_HEADER;
        end else if (rdata_r.status == ST_EMPTY) begin
          res.result_code = RC_ALREADY_FREE;
        end else if (op_r == OP_RELEASE) begin
          // push onto the stored class's list
          wr_en          = 1'b1;
          wr_addr        = offset_r[ADDR_BITS-1:MIN_POW];
          wr_data.status = ST_EMPTY;
          wr_data.cls    = rdata_r.cls;
          wr_data.link   = head_val;
          heads_we       = 1'b1;
          heads_widx     = hdr_pool;
          heads_wdata    = offset_r;
        end else if ((status_r == ST_VALID) || (status_r == ST_ACTIVE)) begin
          wr_en          = 1'b1;
          wr_addr        = offset_r[ADDR_BITS-1:MIN_POW];
          wr_data.status = status_e'(status_r);
          wr_data.cls    = rdata_r.cls;
          wr_data.link   = rdata_r.link;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (can_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      end_r       <= END_W'(INITIAL_END);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) class_heads_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + SLOT_BITS'(1);
      if (exec_go) begin
        end_r <= end_nxt;
        if (heads_we) class_heads_r[heads_widx] <= heads_wdata;
      end
      if (exec_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_data.opcode;
      too_large_r <= si.too_large;
      cls_r       <= si.cls;
      bytes_r     <= si.bytes;
      head_r      <= head_val;
      offset_r    <= in_data.block_offset;
      status_r    <= in_data.new_status;
    end
    if (exec_go) out_data_r <= res;
  end

endmodule

/* rtl/sba_checker.sv */
// Port-level checks for the segregated block allocator, bound to the top level.
// Depends on sba_pkg and segregated_block_allocator.
`timescale 1ns / 1ps

module sba_checker import sba_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a pending result holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous still evaluating");

  // failed operations grant no offset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_code != RC_OK) |-> out_data.granted_offset == '0)
    else $error("offset granted on error");

  // oversize reports no class
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_code == RC_TOO_LARGE) |-> out_data.pool_index == '0)
    else $error("class reported with size error");

endmodule

bind segregated_block_allocator sba_checker u_sba_checker (.*);
